>>> src/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Types, constants and helper functions for the EDF resource grant scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

  localparam int NUM_TYPES_MAX = 4;
  localparam int NUM_TYPES_DEF = 4;
  localparam int NUM_PROCS     = 8;
  localparam int MAX_INSTANCES = 8;
  localparam int DUE_BITS      = 16;

  localparam int SLOT_W = $clog2(NUM_PROCS);
  localparam int CNT_W  = 4;
  localparam int CFG_IDX_W = $clog2(NUM_TYPES_MAX);

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [DUE_BITS-1:0]      due_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [MAX_INSTANCES-1:0] map_t;

  typedef cnt_t [NUM_TYPES_MAX-1:0] cnt_vec_t;
  typedef map_t [NUM_TYPES_MAX-1:0] map_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INST_TYPE0 = 2'd0,
    REG_INST_TYPE1 = 2'd1,
    REG_INST_TYPE2 = 2'd2,
    REG_INST_TYPE3 = 2'd3
  } cfg_reg_t;

  localparam cnt_vec_t RESET_COUNTS = {4'd0, 4'd3, 4'd3, 4'd3};

  typedef struct packed {
    slot_t proc_slot;
    logic  has_request;
    due_t  due_time;
    cnt_t  want_type0;
    cnt_t  want_type1;
    cnt_t  want_type2;
    cnt_t  want_type3;
    logic  round_end;
  } in_item_t;

  typedef struct packed {
    logic  granted;
    slot_t winner;
    map_t  grant_mask0;
    map_t  grant_mask1;
    map_t  grant_mask2;
    map_t  grant_mask3;
  } out_item_t;

  // current winner of the round, including the slot in flight
  typedef struct packed {
    logic     found;
    slot_t    slot;
    cnt_vec_t wants;
  } win_t;

  function automatic map_t full_map(input cnt_t count);
    cnt_t sat;
    map_t m;
    sat = (count > cnt_t'(MAX_INSTANCES)) ? cnt_t'(MAX_INSTANCES) : count;
    for (int i = 0; i < MAX_INSTANCES; i++) begin
      m[i] = (i < int'(sat));
    end
    return m;
  endfunction

  function automatic cnt_t pop_count(input map_t m);
    cnt_t c;
    c = '0;
    for (int i = 0; i < MAX_INSTANCES; i++) begin
      c = c + cnt_t'(m[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/edf_free_map.sv
// ----------------------------------------------------------------------------
// edf_free_map
// Free instance maps per resource type: reload on register write, clear
// granted instances at round end, and provide free counts.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_free_map #(
  parameter int NUM_TYPES = edf_pkg::NUM_TYPES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [edf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire edf_pkg::cnt_t                    cfg_wdata,
  input  wire logic                             grant_en,
  input  wire edf_pkg::map_vec_t                grant_mask,
  output edf_pkg::map_vec_t                     free_map,
  output edf_pkg::cnt_vec_t                     free_cnt
);
  import edf_pkg::*;

  logic [NUM_TYPES_MAX-1:0] cfg_hit;

  always_comb begin
    cfg_hit = '0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_INST_TYPE0: cfg_hit[0] = 1'b1;
        REG_INST_TYPE1: cfg_hit[1] = 1'b1;
        REG_INST_TYPE2: cfg_hit[2] = 1'b1;
        REG_INST_TYPE3: cfg_hit[3] = 1'b1;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_TYPES_MAX; k++) begin : g_type
    if (k < NUM_TYPES) begin : g_used
      map_t free_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          free_r <= full_map(RESET_COUNTS[k]);
        end else if (cfg_hit[k]) begin
          free_r <= full_map(cfg_wdata);
        end else if (grant_en) begin
          free_r <= free_r & ~grant_mask[k];
        end
      end

      assign free_map[k] = free_r;
    end else begin : g_unused
      assign free_map[k] = '0;
    end
    assign free_cnt[k] = pop_count(free_map[k]);
  end

endmodule

`default_nettype wire

>>> src/edf_best_track.sv
// ----------------------------------------------------------------------------
// edf_best_track
// Qualify each slot against the free counts and keep the qualifying slot
// with the earliest deadline for the current round.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_best_track #(
  parameter int NUM_TYPES = edf_pkg::NUM_TYPES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire edf_pkg::in_item_t   item,
  input  wire edf_pkg::cnt_vec_t   free_cnt,
  output edf_pkg::win_t            win
);
  import edf_pkg::*;

  due_t     best_due_r;
  slot_t    best_slot_r;
  cnt_vec_t best_wants_r;
  logic     found_r;

  cnt_vec_t wants_in;
  logic     fits;
  logic     take;

  assign wants_in = {item.want_type3, item.want_type2, item.want_type1, item.want_type0};

  always_comb begin
    fits = item.has_request;
    for (int k = 0; k < NUM_TYPES; k++) begin
      if (wants_in[k] > free_cnt[k]) begin
        fits = 1'b0;
      end
    end
  end

  assign take = fits && (!found_r || (item.due_time < best_due_r));

  assign win.found = found_r || take;
  assign win.slot  = take ? item.proc_slot : best_slot_r;
  assign win.wants = take ? wants_in : best_wants_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_due_r   <= '1;
      best_slot_r  <= '0;
      best_wants_r <= '0;
      found_r      <= 1'b0;
    end else if (step) begin
      if (item.round_end) begin
        best_due_r   <= '1;
        best_slot_r  <= '0;
        best_wants_r <= '0;
        found_r      <= 1'b0;
      end else if (take) begin
        best_due_r   <= item.due_time;
        best_slot_r  <= item.proc_slot;
        best_wants_r <= wants_in;
        found_r      <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/edf_grant_pick.sv
// ----------------------------------------------------------------------------
// edf_grant_pick
// Pick the lowest-numbered free instances of each type for the round winner
// and build the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_grant_pick #(
  parameter int NUM_TYPES = edf_pkg::NUM_TYPES_DEF
) (
  input  wire edf_pkg::win_t       win,
  input  wire edf_pkg::map_vec_t   free_map,
  output edf_pkg::map_vec_t        grant_mask,
  output edf_pkg::out_item_t       result
);
  import edf_pkg::*;

  always_comb begin
    cnt_t seen;
    grant_mask = '0;
    for (int k = 0; k < NUM_TYPES; k++) begin
      seen = '0;
      for (int i = 0; i < MAX_INSTANCES; i++) begin
        if (free_map[k][i] && (seen < win.wants[k]) && win.found) begin
          grant_mask[k][i] = 1'b1;
        end
        seen = seen + cnt_t'(free_map[k][i]);
      end
    end
  end

  assign result.granted     = win.found;
  assign result.winner      = win.found ? win.slot : '0;
  assign result.grant_mask0 = grant_mask[0];
  assign result.grant_mask1 = grant_mask[1];
  assign result.grant_mask2 = grant_mask[2];
  assign result.grant_mask3 = grant_mask[3];

endmodule

`default_nettype wire

>>> src/edf_resource_grant_scheduler.sv
// Flow: a round-end transaction is accepted into the input register, and its result is
// loaded into the result register when it leaves the input register, which raises out_valid.
// Throughput: one slot per cycle; the single pass from the input register to the
// result register sets it, and only a round-end slot waits on a held result.
// Reset: synchronous; free maps reload to 3, 3, 3 and 0 instances, the running
// best clears and both registers go empty.
// ----------------------------------------------------------------------------
// edf_resource_grant_scheduler
// Earliest-deadline-first resource grant scheduler: input register, slot
// qualification and best tracking, grant pick, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_resource_grant_scheduler #(
  parameter int NUM_TYPES = edf_pkg::NUM_TYPES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire edf_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output edf_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [edf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire edf_pkg::cnt_t                 cfg_wdata
);
  import edf_pkg::*;

  logic      stage_valid_r;
  in_item_t  stage_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      step;
  logic      in_fire;
  logic      out_open;
  map_vec_t  free_map;
  cnt_vec_t  free_cnt;
  map_vec_t  grant_mask;
  win_t      win;
  out_item_t result;

  assign out_open = !out_valid_r || !out_stall;
  assign step     = stage_valid_r && (!stage_item_r.round_end || out_open);
  assign in_stall = stage_valid_r && !step;
  assign in_fire  = in_valid && !in_stall;

  edf_free_map #(.NUM_TYPES(NUM_TYPES)) u_free_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .grant_en   (step && stage_item_r.round_end),
    .grant_mask (grant_mask),
    .free_map   (free_map),
    .free_cnt   (free_cnt)
  );

  edf_best_track #(.NUM_TYPES(NUM_TYPES)) u_best_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (stage_item_r),
    .free_cnt (free_cnt),
    .win      (win)
  );

  edf_grant_pick #(.NUM_TYPES(NUM_TYPES)) u_grant_pick (
    .win        (win),
    .free_map   (free_map),
    .grant_mask (grant_mask),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_fire) begin
      stage_valid_r <= 1'b1;
    end else if (step) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && stage_item_r.round_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && stage_item_r.round_end) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire
